>>> hdl/frame_slot_manager_macros.svh
// assertion macros for the frame slot manager rtl
`ifndef FRAME_SLOT_MANAGER_MACROS_SVH
`define FRAME_SLOT_MANAGER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define FSLOT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define FSLOT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/fslot_pkg.sv
// types and constants of the frame slot manager
package fslot_pkg;

   localparam int SLOT_COUNT_DEF = 2;
   localparam int SEQ_W          = 64;

   typedef enum logic [2:0] {
      REQ_ACQUIRE         = 3'd0,
      REQ_PREPARE_DONE    = 3'd1,
      REQ_PUBLISH_SELECT  = 3'd2,
      REQ_PUBLISH_RESTORE = 3'd3,
      REQ_PUBLISH_COMMIT  = 3'd4,
      REQ_RETAIN          = 3'd5,
      REQ_RELEASE         = 3'd6,
      REQ_RESET           = 3'd7
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_FREE       = 3'd0,
      ST_PREPARING  = 3'd1,
      ST_READY      = 3'd2,
      ST_PUBLISHING = 3'd3,
      ST_RETAINED   = 3'd4
   } slot_state_type;

   typedef struct packed {
      logic [2:0]       req_type;
      logic             slot_index;
      logic             exclusive_sample;
      logic             allow_supersede;
      logic             op_ok;
      logic             needs_frame;
      logic             has_timing_token;
      logic [SEQ_W-1:0] content_serial;
   } req_item_type;

   typedef struct packed {
      logic             granted;
      logic             granted_slot;
      logic [1:0]       superseded_count;
      logic [SEQ_W-1:0] ready_sequence;
      logic             force_frame;
      logic             frame_available;
      logic             status;
   } rsp_item_type;

   function automatic logic is_complete(slot_state_type s);
      return (s == ST_READY) || (s == ST_PUBLISHING) || (s == ST_RETAINED);
   endfunction

endpackage

>>> hdl/fslot_req_if.sv
// request channel of the frame slot manager
interface fslot_req_if import fslot_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [2:0]       req_type;
   logic             slot_index;
   logic             exclusive_sample;
   logic             allow_supersede;
   logic             op_ok;
   logic             needs_frame;
   logic             has_timing_token;
   logic [SEQ_W-1:0] content_serial;

   modport source (
      output valid, req_type, slot_index, exclusive_sample, allow_supersede,
             op_ok, needs_frame, has_timing_token, content_serial,
      input  ready
   );
   modport sink (
      input  valid, req_type, slot_index, exclusive_sample, allow_supersede,
             op_ok, needs_frame, has_timing_token, content_serial,
      output ready
   );
endinterface

>>> hdl/fslot_rsp_if.sv
// response channel of the frame slot manager
interface fslot_rsp_if import fslot_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             granted;
   logic             granted_slot;
   logic [1:0]       superseded_count;
   logic [SEQ_W-1:0] ready_sequence;
   logic             force_frame;
   logic             frame_available;
   logic             status;

   modport source (
      output valid, granted, granted_slot, superseded_count, ready_sequence,
             force_frame, frame_available, status,
      input  ready
   );
   modport sink (
      input  valid, granted, granted_slot, superseded_count, ready_sequence,
             force_frame, frame_available, status,
      output ready
   );
endinterface

>>> hdl/fslot_engine.sv
// next slot state and response for one event, from registered slot state
module fslot_engine import fslot_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  req_item_type   item,
   input  slot_state_type state_q [SLOT_COUNT],
   input  logic [SEQ_W-1:0] seq_q [SLOT_COUNT],
   input  slot_state_type saved_q [SLOT_COUNT],
   output slot_state_type state_d [SLOT_COUNT],
   output logic [SEQ_W-1:0] seq_d [SLOT_COUNT],
   output slot_state_type saved_d [SLOT_COUNT],
   output rsp_item_type   result
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   // slot_index is one bit wide, so it always addresses an existing slot
   always_comb begin
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] sel;
      logic             found;
      logic             idle;
      logic             any_pub;
      logic             any_ret;
      logic             newer;
      logic             any_ready;
      logic [CNT_W-1:0] ready_cnt;
      logic [CNT_W-1:0] dropped;
      logic [SEQ_W-1:0] best;
      logic             force_f;
      logic [SEQ_W-1:0] rseq;

      idx       = IDX_W'(item.slot_index);
      sel       = '0;
      found     = 1'b0;
      idle      = 1'b1;
      any_pub   = 1'b0;
      any_ret   = 1'b0;
      newer     = 1'b0;
      any_ready = 1'b0;
      ready_cnt = '0;
      dropped   = '0;
      best      = '1;
      force_f   = 1'b0;
      rseq      = '0;
      state_d   = state_q;
      seq_d     = seq_q;
      saved_d   = saved_q;
      result    = '0;

      case (req_kind_type'(item.req_type))
         REQ_ACQUIRE: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (state_q[i] == ST_RETAINED) begin
                  any_ret = 1'b1;
               end else if (state_q[i] != ST_FREE) begin
                  idle = 1'b0;
                  if (state_q[i] == ST_PUBLISHING) any_pub = 1'b1;
               end else if (!found) begin
                  found = 1'b1;
                  sel   = IDX_W'(i);
               end
               if (state_q[i] == ST_READY) ready_cnt = ready_cnt + CNT_W'(1);
            end
            if (item.exclusive_sample && !idle) found = 1'b0;
            // supersede the oldest ready frame, keeping one if nothing else is shown
            if (item.allow_supersede && !item.exclusive_sample && !found &&
                ((any_pub || any_ret) ? (ready_cnt != '0) : (ready_cnt > CNT_W'(1)))) begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (state_q[i] == ST_READY && seq_q[i] < best) begin
                     found = 1'b1;
                     sel   = IDX_W'(i);
                     best  = seq_q[i];
                  end
               end
            end
            if (found) begin
               if (state_q[sel] == ST_READY) dropped = CNT_W'(1);
               state_d[sel]        = ST_PREPARING;
               seq_d[sel]          = item.content_serial;
               result.granted      = 1'b1;
               result.granted_slot = sel[0];
            end
         end
         REQ_PREPARE_DONE: begin
            force_f = !item.op_ok;
            if (state_q[idx] != ST_PREPARING) begin
               result.status = 1'b1;
            end else if (item.op_ok) begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (IDX_W'(i) != idx) begin
                     if (is_complete(state_q[i]) && seq_q[i] > seq_q[idx]) begin
                        newer = 1'b1;
                     end else if (state_q[i] == ST_RETAINED) begin
                        state_d[i] = ST_FREE;
                     end
                  end
               end
               if (newer) begin
                  state_d[idx] = ST_FREE;
               end else begin
                  state_d[idx] = ST_READY;
                  rseq         = seq_q[idx];
                  if (item.has_timing_token) force_f = 1'b1;
               end
            end else begin
               state_d[idx] = ST_FREE;
            end
         end
         REQ_PUBLISH_SELECT: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (state_q[i] == ST_READY && (!found || seq_q[i] > best)) begin
                  found = 1'b1;
                  sel   = IDX_W'(i);
                  best  = seq_q[i];
               end
            end
            if (!found && item.needs_frame) begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (state_q[i] == ST_RETAINED && (!found || seq_q[i] > best)) begin
                     found = 1'b1;
                     sel   = IDX_W'(i);
                     best  = seq_q[i];
                  end
               end
            end
            if (found) begin
               saved_d[sel]        = state_q[sel];
               state_d[sel]        = ST_PUBLISHING;
               result.granted      = 1'b1;
               result.granted_slot = sel[0];
            end
         end
         REQ_PUBLISH_RESTORE: begin
            if (state_q[idx] != ST_PUBLISHING) result.status = 1'b1;
            else                               state_d[idx] = saved_q[idx];
         end
         REQ_PUBLISH_COMMIT: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (state_q[i] == ST_READY && seq_q[i] < seq_q[idx]) begin
                  state_d[i] = ST_FREE;
                  dropped    = dropped + CNT_W'(1);
               end
            end
         end
         REQ_RETAIN: begin
            if (state_q[idx] != ST_PUBLISHING) begin
               result.status = 1'b1;
            end else begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (IDX_W'(i) != idx) begin
                     if (is_complete(state_q[i]) && seq_q[i] > seq_q[idx]) begin
                        newer = 1'b1;
                     end else if (seq_q[i] < seq_q[idx] &&
                                  (state_q[i] == ST_READY || state_q[i] == ST_RETAINED)) begin
                        if (state_q[i] == ST_READY) dropped = dropped + CNT_W'(1);
                        state_d[i] = ST_FREE;
                     end
                  end
               end
               state_d[idx] = newer ? ST_FREE : ST_RETAINED;
            end
         end
         REQ_RELEASE: begin
            state_d[idx] = ST_FREE;
         end
         REQ_RESET: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               state_d[i] = ST_FREE;
               seq_d[i]   = '0;
               saved_d[i] = ST_FREE;
            end
         end
         default: begin
            result.status = 1'b1;
         end
      endcase

      any_ret = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (state_d[i] == ST_READY)         any_ready = 1'b1;
         else if (state_d[i] == ST_RETAINED) any_ret   = 1'b1;
      end

      result.superseded_count = (dropped > CNT_W'(3)) ? 2'd3 : dropped[1:0];
      result.ready_sequence   = rseq;
      result.force_frame      = force_f;
      result.frame_available  = any_ready || (any_ret && item.needs_frame);
   end

endmodule

>>> hdl/frame_slot_manager.sv
// frame slot manager top level: request register, slot state and response register
//
// Bookkeeping for a small pool of frame slots shared by a producer (acquire,
// prepare) and a consumer (publish). Each request transaction is an event:
// acquire, prepare done, publish select, publish restore, publish commit,
// retain, release or reset, and each one returns exactly one response
// transaction with the granted slot, the number of ready frames dropped, the
// sequence that became ready, and the force-frame, frame-available and status
// flags. A request is captured in an input register; once the response
// register is free or drained, the event is applied to the registered slot
// table in one pass and the response is written to the output register.
// One request is taken every cycle while responses are being taken. The
// slot table is updated in the same cycle that the response is loaded, so
// back-to-back requests always see the effect of their predecessors. While
// a response waits, one further request is held in the input register.
// Reset clears every slot to free with sequence zero.
`include "frame_slot_manager_macros.svh"

module frame_slot_manager import fslot_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   fslot_req_if.sink   req,
   fslot_rsp_if.source rsp
);

   // input register
   logic             req_valid_ff, req_valid_in;
   req_item_type     req_item_ff, req_item_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff;
   rsp_item_type     rsp_item_in;

   // slot table
   slot_state_type   state_ff [SLOT_COUNT];
   slot_state_type   state_in [SLOT_COUNT];
   logic [SEQ_W-1:0] seq_ff   [SLOT_COUNT];
   logic [SEQ_W-1:0] seq_in   [SLOT_COUNT];
   slot_state_type   saved_ff [SLOT_COUNT];
   slot_state_type   saved_in [SLOT_COUNT];

   logic             advance;
   logic             take_req;

   // the held request moves on whenever the response register is free or drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !req_valid_ff || advance;
   assign take_req  = req.valid && req.ready;

   always_comb begin
      req_valid_in = take_req ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
      req_item_in  = req_item_ff;
      if (take_req) begin
         req_item_in.req_type         = req.req_type;
         req_item_in.slot_index       = req.slot_index;
         req_item_in.exclusive_sample = req.exclusive_sample;
         req_item_in.allow_supersede  = req.allow_supersede;
         req_item_in.op_ok            = req.op_ok;
         req_item_in.needs_frame      = req.needs_frame;
         req_item_in.has_timing_token = req.has_timing_token;
         req_item_in.content_serial   = req.content_serial;
      end
      rsp_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   // event evaluation against the current slot table
   fslot_engine #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_engine (
      .item    (req_item_ff),
      .state_q (state_ff),
      .seq_q   (seq_ff),
      .saved_q (saved_ff),
      .state_d (state_in),
      .seq_d   (seq_in),
      .saved_d (saved_in),
      .result  (rsp_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            state_ff[i] <= ST_FREE;
            seq_ff[i]   <= '0;
            saved_ff[i] <= ST_FREE;
         end
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
            seq_ff   <= seq_in;
            saved_ff <= saved_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      if (advance) rsp_item_ff <= rsp_item_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.granted          = rsp_item_ff.granted;
   assign rsp.granted_slot     = rsp_item_ff.granted_slot;
   assign rsp.superseded_count = rsp_item_ff.superseded_count;
   assign rsp.ready_sequence   = rsp_item_ff.ready_sequence;
   assign rsp.force_frame      = rsp_item_ff.force_frame;
   assign rsp.frame_available  = rsp_item_ff.frame_available;
   assign rsp.status           = rsp_item_ff.status;

   // a held request stays put until the response side can take it
   `FSLOT_ASSERT_NXT(a_hold_req, clock, reset, req_valid_ff && !advance,
      req_valid_ff && $stable(req_item_ff), "held request changed while stalled")

   // every request that moves on produces a response
   `FSLOT_ASSERT_NXT(a_rsp_loaded, clock, reset, advance, rsp_valid_ff,
      "request advanced without a response")

   // a grant comes only from acquire or publish select, which are never ignored
   `FSLOT_ASSERT_IMP(a_grant_status, clock, reset, rsp_valid_ff && rsp_item_ff.granted,
      !rsp_item_ff.status && rsp_item_ff.ready_sequence == '0,
      "grant with status or ready sequence set")

   // a ready sequence is reported only by a successful prepare done
   `FSLOT_ASSERT_IMP(a_ready_seq, clock, reset,
      rsp_valid_ff && rsp_item_ff.ready_sequence != '0,
      !rsp_item_ff.status && rsp_item_ff.frame_available &&
      rsp_item_ff.superseded_count == 2'd0,
      "ready sequence without a ready slot")

endmodule
